FILE: src/sic_pkg.sv
// Shared types and constants of the striped command generator.
package sic_pkg;

    localparam int MAX_OBJECTS = 16;

    localparam int LBA_SHIFT = 12;
    localparam int LBA_BYTES = 1 << LBA_SHIFT;

    localparam int ADDR_W = 48;
    localparam int CNT_W  = 16;
    localparam int ERR_W  = 32;
    localparam int OBJ_W  = 4;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 48;

    // result kinds
    localparam logic [1:0] KIND_CMD      = 2'd0;
    localparam logic [1:0] KIND_FINISHED = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;
    localparam logic [1:0] KIND_ALIGN    = 2'd3;

    // input actions
    localparam logic ACT_LAUNCH   = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_CHUNK_BYTES    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_OBJECT_BLOCKS  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_STRIPE_TOTAL   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TRANSFER_BYTES = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TRANSFER_START = 3'd4;
    localparam logic [CFG_AW-1:0] REG_OBJECT_COUNT   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_OBJECT_START   = 3'd6;
    localparam logic [CFG_AW-1:0] REG_WRITE_MODE     = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_FIRST,
        S_MUL1,
        S_X1,
        S_DIV2,
        S_Q2,
        S_MUL2,
        S_LBA,
        S_C_READ,
        S_C_OFF,
        S_C_NEXT,
        S_EMIT
    } t_state;

    // one object's current command, as kept in the object memory
    typedef struct packed {
        logic [ADDR_W-1:0] lba;
        logic [CNT_W-1:0]  m1;
        logic [ADDR_W-1:0] off;
    } t_obj;

endpackage

FILE: src/striped_io_command_generator.sv
// Striped I/O command generator: launch and completion sequencer over an object memory.
//
// Usage: configure the eight registers through the write port (i_cfg_we, i_cfg_addr,
// i_cfg_wdata) while the block is idle, then send items on the slave stream. tuser[0]
// is the action: 0 launches the next object, 1 reports a completion for the object in
// tdata[3:0] with its error flag in tdata[4]. Each item yields at most one result on
// the master stream: tuser[1:0] is the kind (command, object finished, launch done,
// alignment error), tdata carries the command fields.
// A launch runs two 64-step shift-subtract divisions and two multiplications (three
// 32x32 partial products each) on one shared divider and multiplier; a refused launch
// goes straight from the idle step to the emit step. A completion reads the object
// memory, adds and compares in the read, offset and next steps before its result.
// A completion for an object index at or beyond MAX_OBJECTS is dropped without result.
// One item is in work at a time; s_axis_tready is high while the sequencer is idle,
// so the next item is taken while the previous result still waits in the output register.
// A new item is accepted only after the previous one has left the emit step.
// If the receiver stalls, the finished result waits in the sequencer until the output
// register frees; no result is lost. Reset clears the launch position, the error count
// and the configuration to its defaults; the object memory is not cleared.
module striped_io_command_generator
    import sic_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // object_index[3:0], completion_error[4]
    input  logic [0:0]          s_axis_tuser,   // action[0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_object[3:0], start_lba[51:4], blocks_minus_one[67:52],
    // buffer_offset[115:68], is_write[116], errors_seen[148:117]
    output logic [151:0]        m_axis_tdata,
    output logic [1:0]          m_axis_tuser    // result_kind[1:0]
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    // configuration
    logic [28:0]       r_chunk;
    logic [31:0]       r_obj_blocks;
    logic [ADDR_W-1:0] r_stripe;
    logic [ADDR_W-1:0] r_xfer;
    logic [ADDR_W-1:0] r_xfer_start;
    logic [4:0]        r_obj_count;
    logic [ADDR_W-1:0] r_obj_start;
    logic              r_write_mode;

    // control state
    t_state            r_state, n_state;
    logic [4:0]        r_launch_index;
    logic [ADDR_W-1:0] r_launch_offset;
    logic [ERR_W-1:0]  r_err_total;

    // datapath
    logic [63:0]       r_dq, r_dr;
    logic [ADDR_W-1:0] r_dd;
    logic [5:0]        r_dcnt;
    logic [63:0]       r_ma, r_mb, r_acc, r_pp;
    logic [1:0]        r_mcnt;
    logic [63:0]       r_x, r_r;
    logic [CNT_W-1:0]  r_m1;
    logic [OBJ_W-1:0]  r_idx;
    logic [33:0]       r_cprod;
    logic [ADDR_W-1:0] r_off;

    // pending result
    logic [1:0]        r_res_kind;
    logic [OBJ_W-1:0]  r_res_obj;
    logic [ADDR_W-1:0] r_res_lba;
    logic [CNT_W-1:0]  r_res_m1;
    logic [ADDR_W-1:0] r_res_off;
    logic              r_res_wr;

    // output register
    logic              r_out_valid;
    logic [151:0]      r_out_data;
    logic [1:0]        r_out_user;

    // object memory
    t_obj              mem [MAX_OBJECTS];
    t_obj              r_mem_q;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_obj              mem_wdata;

    logic              in_acc;
    logic              out_free;
    logic              in_action;
    logic [OBJ_W-1:0]  in_idx;
    logic              in_err;
    logic              misaligned;
    logic              exhausted;
    logic              idx_ok;
    logic [ADDR_W-1:0] pos;

    logic [63:0]       d_shift;
    logic [64:0]       d_diff;
    logic              d_ge;
    logic [63:0]       pp;

    logic [28:0]       rem_c;
    logic [ADDR_W-1:0] first;
    logic [CNT_W-1:0]  first_m1;
    logic [63:0]       x1;
    logic [63:0]       x2;
    logic [ADDR_W-1:0] lba_new;
    logic [CNT_W:0]    m1p1_launch;
    logic [CNT_W:0]    m1p1_obj;
    logic [4:0]        others;
    logic [ADDR_W-1:0] off_new;
    logic [ADDR_W-1:0] left;
    logic [ADDR_W-1:0] next_len;
    logic [CNT_W-1:0]  next_m1;
    logic [ADDR_W-1:0] next_lba;
    logic              more;

    assign in_action  = s_axis_tuser[0];
    assign in_idx     = s_axis_tdata[3:0];
    assign in_err     = s_axis_tdata[4];
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_out_valid || m_axis_tready;

    assign misaligned = (r_xfer[LBA_SHIFT-1:0] != '0) || (r_xfer_start[LBA_SHIFT-1:0] != '0);
    assign exhausted  = (r_launch_index >= r_obj_count) || (32'(r_launch_index) >= MAX_OBJECTS)
                        || (r_launch_offset >= r_xfer);
    assign idx_ok     = 32'(in_idx) < MAX_OBJECTS;
    assign pos        = r_launch_offset + r_xfer_start;

    // restoring division step
    assign d_shift = {r_dr[62:0], r_dq[63]};
    assign d_diff  = {1'b0, d_shift} - {17'b0, r_dd};
    assign d_ge    = !d_diff[64];

    // 32x32 partial products of a 64-bit product kept modulo 2^64
    always_comb begin
        case (r_mcnt)
            2'd0:    pp = {32'b0, r_ma[31:0]} * {32'b0, r_mb[31:0]};
            2'd1:    pp = {32'b0, r_ma[31:0]} * {32'b0, r_mb[63:32]};
            2'd2:    pp = {32'b0, r_ma[63:32]} * {32'b0, r_mb[31:0]};
            default: pp = '0;
        endcase
    end

    // first command length from the chunk remainder
    assign rem_c    = (r_chunk == '0) ? '0 : r_chunk - r_dr[28:0];
    assign first    = (r_xfer < {19'b0, rem_c}) ? r_xfer : {19'b0, rem_c};
    assign first_m1 = first[LBA_SHIFT +: CNT_W] - 16'd1;

    assign x1      = r_r + r_acc;
    assign x2      = r_r + r_acc;
    assign lba_new = x2[LBA_SHIFT +: ADDR_W] + {{LBA_SHIFT{1'b0}}, r_obj_start[ADDR_W-1:LBA_SHIFT]};
    assign m1p1_launch = {1'b0, r_m1} + 17'd1;

    // completion: step past the other objects' chunks
    assign others   = (r_obj_count == '0) ? '0 : r_obj_count - 5'd1;
    assign m1p1_obj = {1'b0, r_mem_q.m1} + 17'd1;
    assign off_new  = r_mem_q.off + ADDR_W'({m1p1_obj, {LBA_SHIFT{1'b0}}})
                      + {14'b0, r_cprod};
    assign more     = r_off < r_xfer;
    assign left     = r_xfer - r_off;
    assign next_len = ({19'b0, r_chunk} < left) ? {19'b0, r_chunk} : left;
    assign next_m1  = next_len[LBA_SHIFT +: CNT_W] - 16'd1;
    assign next_lba = r_mem_q.lba + {31'b0, m1p1_obj};

    // next state and memory write
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_idx);
        mem_wdata = '{lba: next_lba, m1: next_m1, off: r_off};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_action == ACT_LAUNCH) begin
                        n_state = (misaligned || exhausted) ? S_EMIT : S_DIV1;
                    end else if (idx_ok) begin
                        n_state = S_C_READ;
                    end
                end
            end
            S_DIV1:   if (r_dcnt == 6'd63) n_state = S_FIRST;
            S_FIRST:  n_state = S_MUL1;
            S_MUL1:   if (r_mcnt == 2'd3) n_state = S_X1;
            S_X1:     n_state = S_DIV2;
            S_DIV2:   if (r_dcnt == 6'd63) n_state = S_Q2;
            S_Q2:     n_state = S_MUL2;
            S_MUL2:   if (r_mcnt == 2'd3) n_state = S_LBA;
            S_LBA: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_launch_index);
                mem_wdata = '{lba: lba_new, m1: r_m1, off: r_launch_offset};
                n_state   = S_EMIT;
            end
            S_C_READ: n_state = S_C_OFF;
            S_C_OFF:  n_state = S_C_NEXT;
            S_C_NEXT: begin
                mem_we = 1'b1;
                if (!more) begin
                    mem_wdata = '{lba: r_mem_q.lba, m1: r_mem_q.m1, off: r_off};
                end
                n_state = S_EMIT;
            end
            S_EMIT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk      <= 29'd65536;
            r_obj_blocks <= 32'd4096;
            r_stripe     <= 48'd262144;
            r_xfer       <= '0;
            r_xfer_start <= '0;
            r_obj_count  <= 5'd4;
            r_obj_start  <= '0;
            r_write_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CHUNK_BYTES:    r_chunk      <= i_cfg_wdata[28:0];
                REG_OBJECT_BLOCKS:  r_obj_blocks <= i_cfg_wdata[31:0];
                REG_STRIPE_TOTAL:   r_stripe     <= i_cfg_wdata;
                REG_TRANSFER_BYTES: r_xfer       <= i_cfg_wdata;
                REG_TRANSFER_START: r_xfer_start <= i_cfg_wdata;
                REG_OBJECT_COUNT:   r_obj_count  <= i_cfg_wdata[4:0];
                REG_OBJECT_START:   r_obj_start  <= i_cfg_wdata;
                REG_WRITE_MODE:     r_write_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // launch position and error count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_index  <= '0;
            r_launch_offset <= '0;
            r_err_total     <= '0;
        end else begin
            if (r_state == S_LBA) begin
                r_launch_offset <= r_launch_offset
                                   + ADDR_W'({m1p1_launch, {LBA_SHIFT{1'b0}}});
                r_launch_index  <= r_launch_index + 5'd1;
            end
            if (in_acc && in_action == ACT_COMPLETE && idx_ok && in_err
                && r_err_total != '1) begin
                r_err_total <= r_err_total + 32'd1;
            end
        end
    end

    // divider, multiplier and result staging
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx      <= in_idx;
                r_res_obj  <= '0;
                r_res_lba  <= '0;
                r_res_m1   <= '0;
                r_res_off  <= '0;
                r_res_wr   <= 1'b0;
                r_res_kind <= misaligned ? KIND_ALIGN : KIND_DONE;
                r_x        <= {16'b0, pos};
                r_dq       <= {16'b0, pos};
                r_dr       <= '0;
                r_dd       <= {19'b0, r_chunk};
                r_dcnt     <= '0;
            end
            S_DIV1, S_DIV2: begin
                r_dq   <= {r_dq[62:0], d_ge};
                r_dr   <= d_ge ? d_diff[63:0] : d_shift;
                r_dcnt <= r_dcnt + 6'd1;
            end
            S_FIRST: begin
                r_m1   <= first_m1;
                r_r    <= (r_dd == '0) ? r_x : r_dr;
                r_ma   <= (r_dd == '0) ? '0 : r_dq;
                r_mb   <= {20'b0, r_obj_blocks, {LBA_SHIFT{1'b0}}};
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            S_MUL1, S_MUL2: begin
                r_pp   <= pp;
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd1) begin
                    r_acc <= r_acc + r_pp;
                end else if (r_mcnt != 2'd0) begin
                    r_acc <= r_acc + {r_pp[31:0], 32'b0};
                end
            end
            S_X1: begin
                r_x    <= x1;
                r_dq   <= x1;
                r_dr   <= '0;
                r_dd   <= r_stripe;
                r_dcnt <= '0;
            end
            S_Q2: begin
                r_r    <= (r_dd == '0) ? r_x : r_dr;
                r_ma   <= (r_dd == '0) ? '0 : r_dq;
                r_mb   <= {35'b0, r_chunk};
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            S_LBA: begin
                r_res_kind <= KIND_CMD;
                r_res_obj  <= r_launch_index[OBJ_W-1:0];
                r_res_lba  <= lba_new;
                r_res_m1   <= r_m1;
                r_res_off  <= r_launch_offset;
                r_res_wr   <= r_write_mode;
            end
            S_C_READ: begin
                r_cprod <= {5'b0, r_chunk} * {29'b0, others};
            end
            S_C_OFF: begin
                r_off <= off_new;
            end
            S_C_NEXT: begin
                r_res_obj <= r_idx;
                if (more) begin
                    r_res_kind <= KIND_CMD;
                    r_res_lba  <= next_lba;
                    r_res_m1   <= next_m1;
                    r_res_off  <= r_off;
                    r_res_wr   <= r_write_mode;
                end else begin
                    r_res_kind <= KIND_FINISHED;
                end
            end
            default: ;
        endcase
    end

    // object memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_C_READ) begin
            r_mem_q <= mem[AW'(r_idx)];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_user <= r_res_kind;
            r_out_data <= {3'b0, r_err_total, r_res_wr, r_res_off, r_res_m1,
                           r_res_lba, r_res_obj};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_cmpl_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_action == ACT_COMPLETE && idx_ok |=> r_state == S_C_READ)
        else $error("in-range completion did not start a memory read");

    a_launch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_launch_index) <= MAX_OBJECTS)
        else $error("launch index ran past the object memory");

    a_err_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_err_total >= $past(r_err_total))
        else $error("error count went down");

    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside the emit step");

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready)
        else $error("item taken while another is in work");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the striped I/O command generator.
`timescale 1ns / 100ps

module tb
    import sic_pkg::*;
();

    typedef bit [63:0] t_u64;

    localparam t_u64 M48 = 64'hFFFF_FFFF_FFFF;
    localparam t_u64 M16 = 64'hFFFF;
    localparam int OBJ_MAX = MAX_OBJECTS;

    typedef struct {
        bit [1:0]  kind;
        bit [3:0]  obj;
        bit [47:0] lba;
        bit [15:0] m1;
        bit [47:0] off;
        bit        wr;
        bit [31:0] errs;
    } t_cmd_res;

    // Expected command stream plus a private copy of the generator state.
    class stripe_scoreboard;
        t_u64 chunk, oblk, stripe, xfer, xstart, ocount, ostart, wmode;
        t_u64 lba_q[OBJ_MAX];
        t_u64 m1_q[OBJ_MAX];
        t_u64 boff_q[OBJ_MAX];
        t_u64 next_obj, next_off, err_total;
        t_cmd_res pending_q[$];
        int fails;
        int kind_cnt[4];

        function new();
            chunk = 65536; oblk = 4096; stripe = 262144; xfer = 0; xstart = 0;
            ocount = 4; ostart = 0; wmode = 0;
            next_obj = 0; next_off = 0; err_total = 0; fails = 0;
            foreach (kind_cnt[i]) kind_cnt[i] = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, t_u64 v);
            case (idx)
                REG_CHUNK_BYTES:    chunk  = v & 64'h1FFF_FFFF;
                REG_OBJECT_BLOCKS:  oblk   = v & 64'hFFFF_FFFF;
                REG_STRIPE_TOTAL:   stripe = v & M48;
                REG_TRANSFER_BYTES: xfer   = v & M48;
                REG_TRANSFER_START: xstart = v & M48;
                REG_OBJECT_COUNT:   ocount = v & 64'h1F;
                REG_OBJECT_START:   ostart = v & M48;
                REG_WRITE_MODE:     wmode  = v & 64'h1;
                default: ;
            endcase
        endfunction

        function t_u64 xlate(t_u64 x, t_u64 d, t_u64 s);
            if (d == 0) return x;
            return x % d + (x / d) * s;
        endfunction

        function void push(bit [1:0] k, t_u64 o, t_u64 l, t_u64 m, t_u64 f, t_u64 w);
            t_cmd_res r;
            r.kind = k; r.obj = o[3:0]; r.lba = l[47:0]; r.m1 = m[15:0];
            r.off = f[47:0]; r.wr = w[0]; r.errs = err_total[31:0];
            pending_q.push_back(r);
        endfunction

        function void note(bit act, bit [3:0] idx, bit err);
            t_u64 pos, rem, first, m1, lba, i, others, off;
            if (act == ACT_LAUNCH) begin
                if ((xfer % LBA_BYTES) != 0 || (xstart % LBA_BYTES) != 0) begin
                    push(KIND_ALIGN, 0, 0, 0, 0, 0);
                end else if (next_obj >= ocount || next_obj >= OBJ_MAX
                             || next_off >= xfer) begin
                    push(KIND_DONE, 0, 0, 0, 0, 0);
                end else begin
                    i = next_obj;
                    pos = (next_off + xstart) & M48;
                    rem = chunk - (chunk == 0 ? 0 : pos % chunk);
                    first = (xfer < rem) ? xfer : rem;
                    m1 = (first / LBA_BYTES - 1) & M16;
                    lba = xlate(pos, chunk, oblk * LBA_BYTES);
                    lba = xlate(lba, stripe, chunk) / LBA_BYTES;
                    lba = (lba + ostart / LBA_BYTES) & M48;
                    lba_q[i] = lba; m1_q[i] = m1; boff_q[i] = next_off;
                    push(KIND_CMD, i, lba, m1, next_off, wmode);
                    next_off = (next_off + (m1 + 1) * LBA_BYTES) & M48;
                    next_obj = next_obj + 1;
                end
            end else begin
                if (err && err_total < 64'hFFFF_FFFF) err_total++;
                others = (ocount == 0) ? 0 : ocount - 1;
                off = (boff_q[idx] + (m1_q[idx] + 1) * LBA_BYTES + chunk * others) & M48;
                boff_q[idx] = off;
                if (off < xfer) begin
                    lba = (lba_q[idx] + m1_q[idx] + 1) & M48;
                    m1 = (((chunk < xfer - off) ? chunk : xfer - off) / LBA_BYTES - 1) & M16;
                    lba_q[idx] = lba; m1_q[idx] = m1;
                    push(KIND_CMD, idx, lba, m1, off, wmode);
                end else begin
                    push(KIND_FINISHED, idx, 0, 0, 0, 0);
                end
            end
        endfunction

        function void cmp(string name, t_u64 e, t_u64 a);
            if (e != a) begin
                $display("%0t: mismatch %s expected %0h actual %0h", $time, name, e, a);
                fails++;
            end
        endfunction

        function void check(bit [1:0] kind, bit [151:0] d);
            t_cmd_res e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected item kind %0d data %0h", $time, kind, d);
                fails++;
                return;
            end
            e = pending_q.pop_front();
            kind_cnt[kind]++;
            cmp("result_kind", e.kind, kind);
            cmp("result_object", e.obj, d[3:0]);
            cmp("start_lba", e.lba, d[51:4]);
            cmp("blocks_minus_one", e.m1, d[67:52]);
            cmp("buffer_offset", e.off, d[115:68]);
            cmp("is_write", e.wr, d[116]);
            cmp("errors_seen", e.errs, d[148:117]);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // object_index[3:0], completion_error[4]
    logic [0:0]        s_axis_tuser;   // action[0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // result_object[3:0], start_lba[51:4], blocks_minus_one[67:52],
    // buffer_offset[115:68], is_write[116], errors_seen[148:117]
    logic [151:0]      m_axis_tdata;
    logic [1:0]        m_axis_tuser;   // result_kind[1:0]

    striped_io_command_generator i_dut (.*);

    stripe_scoreboard sb = new();
    bit    no_idle;
    int    rx_wait;
    int    items_sent;
    t_u64  cfg[8];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[striped_io_command_generator] ERROR");
        $finish;
    end

    // Receiver: check each accepted item, then hold off a random number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            sb.check(m_axis_tuser, m_axis_tdata);
            rx_wait = no_idle ? 0 : $urandom_range(0, 15);
            if (rx_wait > 0) m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            if (rx_wait == 0) m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send(bit act, bit [3:0] idx, bit err);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, err, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(act, idx, err);
        items_sent++;
    endtask

    // Hold the sender until every result is back, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg();
        for (int r = 0; r < 8; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= r[CFG_AW-1:0];
            i_cfg_wdata <= cfg[r][CFG_DW-1:0];
            @(posedge i_clk);
            sb.set_reg(r[CFG_AW-1:0], cfg[r]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_cfg(t_u64 ch, t_u64 ob, t_u64 st, t_u64 xb, t_u64 xs, t_u64 oc,
                           t_u64 os, t_u64 wm);
        cfg[0] = ch; cfg[1] = ob; cfg[2] = st; cfg[3] = xb;
        cfg[4] = xs; cfg[5] = oc; cfg[6] = os; cfg[7] = wm;
        write_cfg();
    endtask

    function automatic t_u64 rnd48();
        return {$urandom(), $urandom()} & M48;
    endfunction

    task automatic random_cfg();
        t_u64 k, ch, oc, st, xb;
        k  = $urandom_range(1, 16);
        ch = ($urandom_range(0, 9) == 0) ? t_u64'($urandom()) & 64'h1FFF_FFFF
                                         : k * LBA_BYTES;
        case ($urandom_range(0, 5))
            0, 1:    oc = 16;
            2:       oc = $urandom_range(0, 31);
            default: oc = $urandom_range(1, 16);
        endcase
        st = ($urandom_range(0, 4) == 0) ? rnd48() : ch * oc;
        xb = ch * (oc == 0 ? 1 : oc) * $urandom_range(1, 30) + LBA_BYTES * $urandom_range(0, 16);
        if ($urandom_range(0, 5) == 0) xb = rnd48() & ~t_u64'(LBA_BYTES - 1);
        if ($urandom_range(0, 9) == 0) xb = xb + $urandom_range(1, LBA_BYTES - 1);
        set_cfg(ch,
                ($urandom_range(0, 3) == 0) ? t_u64'($urandom()) : $urandom_range(1, 64),
                st, xb & M48,
                ($urandom_range(0, 3) == 0) ? (rnd48() & ~t_u64'(LBA_BYTES - 1))
                                            : LBA_BYTES * $urandom_range(0, 64),
                oc, rnd48(), $urandom_range(0, 1));
    endtask

    initial begin
        int launched;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        no_idle       = 1'b0;
        items_sent    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: empty transfer, so a launch reports done.
        send(ACT_LAUNCH, 4'd0, 1'b0);
        drain();

        // Smallest chunk, two objects, writes; launch past the end.
        set_cfg(LBA_BYTES, 1, LBA_BYTES, LBA_BYTES * 2 * 3, 0, 2, 0, 1);
        repeat (3) send(ACT_LAUNCH, 4'd0, 1'b0);
        send(ACT_COMPLETE, 4'd0, 1'b1);
        send(ACT_COMPLETE, 4'd1, 1'b0);
        repeat (2) send(ACT_COMPLETE, 4'd0, 1'b1);
        drain();

        // Misaligned length, then misaligned start.
        set_cfg(LBA_BYTES, 1, LBA_BYTES, LBA_BYTES + 1, 0, 4, 0, 0);
        send(ACT_LAUNCH, 4'd0, 1'b0);
        drain();
        set_cfg(LBA_BYTES, 1, LBA_BYTES, LBA_BYTES * 8, 1, 4, 0, 0);
        send(ACT_LAUNCH, 4'd0, 1'b0);
        drain();

        // Field extremes: widest values everywhere, block count wrap.
        set_cfg(64'h1FFF_FFFF, 64'hFFFF_FFFF, M48, M48 & ~t_u64'(LBA_BYTES - 1),
                M48 & ~t_u64'(LBA_BYTES - 1), 16, M48, 1);
        send(ACT_LAUNCH, 4'd0, 1'b0);
        send(ACT_COMPLETE, 4'd2, 1'b0);
        drain();

        // Zero divisors.
        set_cfg(0, 7, 0, LBA_BYTES * 40, LBA_BYTES * 3, 16, LBA_BYTES, 0);
        send(ACT_LAUNCH, 4'd0, 1'b0);
        send(ACT_COMPLETE, 4'd3, 1'b1);
        drain();

        // No objects: launch reports done, completion adds no other chunks.
        set_cfg(LBA_BYTES * 16, 4, LBA_BYTES * 16, LBA_BYTES * 64, 0, 0, 0, 1);
        send(ACT_LAUNCH, 4'd0, 1'b0);
        send(ACT_COMPLETE, 4'd1, 1'b0);
        drain();

        // Random phases: mostly completions of launched objects under varied settings.
        while (items_sent < 1180) begin
            random_cfg();
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(40, 120)) begin
                launched = sb.next_obj;
                if (launched == 0 || (launched < sb.ocount && launched < OBJ_MAX
                                      && $urandom_range(0, 2) == 0)
                    || $urandom_range(0, 15) == 0)
                    send(ACT_LAUNCH, 4'($urandom()), 1'($urandom_range(0, 1)));
                else
                    send(ACT_COMPLETE, 4'($urandom_range(0, launched - 1)),
                         1'($urandom_range(0, 1)));
            end
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d items over many register settings, %0d objects launched.",
                 items_sent, sb.next_obj);
        $display("Results: %0d commands, %0d finishes, %0d done, %0d alignment errors.",
                 sb.kind_cnt[0], sb.kind_cnt[1], sb.kind_cnt[2], sb.kind_cnt[3]);
        if (sb.fails == 0 && sb.pending_q.size() == 0) begin
            $display("[striped_io_command_generator] OK");
        end else begin
            $display("[striped_io_command_generator] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
src/sic_pkg.sv
src/striped_io_command_generator.sv
test/tb.sv
